@@ rtl/core/fpso_pkg.sv @@
package fpso_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_BASE_INCREMENT = 2'd0;
    localparam logic [1:0] REG_FLUCT_AMOUNT   = 2'd1;
    localparam logic [1:0] REG_SEED           = 2'd2;

    // field and register widths
    localparam int PHASE_W  = 32;
    localparam int BASE_W   = 31;
    localparam int FLUCT_W  = 16;
    localparam int SEED_W   = 32;
    localparam int SAMPLE_W = 24;
    localparam int STEP_W   = 33;
    localparam int OP_W     = 33;
    localparam int PROD_W   = 2 * OP_W;

    // linear congruential generator
    localparam logic [31:0] RAND_MUL   = 32'd1103515245;
    localparam logic [31:0] RAND_ADD   = 32'd12345;
    localparam logic [16:0] RAND_SCALE = 17'd128513;

    // phase constants
    localparam logic [31:0]        QUARTER_CYCLE = 32'h4000_0000;
    localparam logic signed [32:0] HALF_CYCLE    = 33'sh0_8000_0000;

    // sine polynomial coefficients, Q4.28
    localparam logic signed [32:0] SIN_C3 = 33'sd608135157;
    localparam logic signed [32:0] SIN_C1 = 33'sd1377809402;
    localparam logic signed [32:0] SIN_C0 = 33'sd843314144;

    // output saturation bounds, Q1.23
    localparam logic signed [28:0] SAMPLE_MAX = 29'sd8388607;
    localparam logic signed [28:0] SAMPLE_MIN = -29'sd8388608;

endpackage

@@ rtl/core/fluctuating_phase_sine_oscillator_top.sv @@
// Sine oscillator with a phase accumulator and random frequency fluctuation.
// Input channel: i_in_valid / o_in_stall carry one item per audio sample
// (modulation phase, optional phase load). Output channel: o_out_valid /
// i_out_stall carry one Q1.23 sine sample per input item, in order.
// Configuration: i_cfg_we writes base increment, fluctuation depth or seed
// (seed also reloads the generator); write only while the block is idle.
// Datapath: all multiplications run through one 33x33 signed multiplier with
// a registered product under a small sequencer. When the phase wraps, an
// item first steps the generator and recomputes the increment, then runs
// the sine polynomial; without a wrap it goes straight to the polynomial.
// The block stalls its input while an item is in work, so it takes no new
// item until the current one has left the sequencer.
// The output register lets a finished sample wait for the receiver while
// the next item is accepted; if a second sample finishes before the first
// is taken, the sequencer holds in its last step until the register frees.
// Reset (synchronous, active low) clears the phase, step, generator and
// configuration registers, and leaves both channels empty.
module fluctuating_phase_sine_oscillator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [31:0]  i_mod_phase,
    input  logic                i_load_phase,
    input  logic signed [31:0]  i_new_phase,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [23:0]  o_sample,
    // configuration
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_EDGE, S_LCG, S_RND, S_RS, S_FR, S_BH, S_BL, S_SUM, S_SAT,
        S_X, S_T, S_U, S_UM, S_Y, S_YM, S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [30:0] r_base;
    logic [15:0] r_fluct;

    // oscillator state
    logic [31:0] r_osc;
    logic [31:0] r_prev;
    logic [32:0] r_step;
    logic [31:0] r_rs;

    // per-item working registers
    logic [31:0]        r_curr;
    logic signed [32:0] r_x;
    logic [30:0]        r_x2;
    logic signed [32:0] r_t;
    logic signed [32:0] r_u;
    logic [15:0]        r_frac_lo;
    logic [63:0]        r_acc;
    logic signed [65:0] r_prod;

    // output register
    logic               r_out_valid;
    logic signed [23:0] r_sample;

    logic               in_accept;
    logic               out_free;
    logic [31:0]        osc_eff;
    logic signed [32:0] diff;
    logic               wrap_edge;
    logic signed [32:0] two_p;
    logic signed [32:0] x_val;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] product;
    logic signed [33:0] t_full;
    logic signed [33:0] u_full;
    logic [33:0]        step_sum;
    logic signed [28:0] y_full;
    logic signed [23:0] y_sat;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    // phase after an optional load
    assign osc_eff = i_load_phase ? i_new_phase : r_osc;

    // wrap detection: previous minus current beyond half a cycle
    assign diff      = $signed({r_prev[31], r_prev}) - $signed({r_curr[31], r_curr});
    assign wrap_edge = (diff > fpso_pkg::HALF_CYCLE) || (diff < -fpso_pkg::HALF_CYCLE);

    // x = 1/2 - |2 * phase|
    assign two_p = $signed({r_curr, 1'b0});
    assign x_val = r_curr[31] ? (fpso_pkg::HALF_CYCLE + two_p)
                              : (fpso_pkg::HALF_CYCLE - two_p);

    // shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            S_LCG: begin
                op_a = $signed({1'b0, r_rs});
                op_b = $signed({1'b0, fpso_pkg::RAND_MUL});
            end
            S_RS: begin
                op_a = $signed({1'b0, r_rs});
                op_b = $signed({16'b0, fpso_pkg::RAND_SCALE});
            end
            S_FR: begin
                op_a = $signed({16'b0, r_prod[48:32]});
                op_b = $signed({17'b0, r_fluct});
            end
            S_BH: begin
                op_a = $signed({2'b0, r_base});
                op_b = $signed({16'b0, r_prod[32:16]});
            end
            S_BL: begin
                op_a = $signed({2'b0, r_base});
                op_b = $signed({17'b0, r_frac_lo});
            end
            S_X: begin
                op_a = r_x;
                op_b = r_x;
            end
            S_T: begin
                op_a = $signed({2'b0, r_prod[62:32]});
                op_b = fpso_pkg::SIN_C3;
            end
            S_UM: begin
                op_a = r_t;
                op_b = r_x;
                op_b = $signed({2'b0, r_x2});
            end
            S_YM: begin
                op_a = r_u;
                op_b = r_x;
            end
            // keep the final product while the sample waits
            S_OUT: begin
                op_a = r_u;
                op_b = r_x;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign product = op_a * op_b;

    // polynomial terms from the registered product
    assign t_full = r_prod[65:32] - 34'(fpso_pkg::SIN_C1);
    assign u_full = r_prod[65:32] + 34'(fpso_pkg::SIN_C0);

    // increment plus fluctuation, saturated to 33 bits when registered
    assign step_sum = {3'b0, r_base} + {1'b0, r_acc[63:31]};

    // output scaling and saturation
    assign y_full = r_prod[65:37];
    always_comb begin
        if (y_full > fpso_pkg::SAMPLE_MAX) begin
            y_sat = fpso_pkg::SAMPLE_MAX[23:0];
        end else if (y_full < fpso_pkg::SAMPLE_MIN) begin
            y_sat = fpso_pkg::SAMPLE_MIN[23:0];
        end else begin
            y_sat = y_full[23:0];
        end
    end

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        r_prod <= product;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_fluct     <= '0;
            r_osc       <= '0;
            r_prev      <= '0;
            r_step      <= '0;
            r_rs        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fpso_pkg::REG_BASE_INCREMENT: r_base  <= i_cfg_data[30:0];
                    fpso_pkg::REG_FLUCT_AMOUNT:   r_fluct <= i_cfg_data[15:0];
                    fpso_pkg::REG_SEED:           r_rs    <= i_cfg_data;
                    default: ;
                endcase
            end

            // output handshake: load a finished sample or release a taken one
            if ((r_state == S_OUT) && out_free) begin
                r_sample    <= y_sat;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_osc   <= osc_eff;
                        r_curr  <= osc_eff + i_mod_phase - fpso_pkg::QUARTER_CYCLE;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_x     <= x_val;
                    r_state <= wrap_edge ? S_LCG : S_X;
                end
                S_LCG: r_state <= S_RND;
                S_RND: begin
                    r_rs    <= r_prod[31:0] + fpso_pkg::RAND_ADD;
                    r_state <= S_RS;
                end
                S_RS: r_state <= S_FR;
                S_FR: r_state <= S_BH;
                S_BH: begin
                    r_frac_lo <= r_prod[15:0];
                    r_state   <= S_BL;
                end
                S_BL: begin
                    r_acc   <= {r_prod[47:0], 16'b0};
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= r_acc + r_prod[63:0];
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_step  <= step_sum[33] ? {33{1'b1}} : step_sum[32:0];
                    r_state <= S_X;
                end
                S_X: begin
                    r_osc   <= r_osc + r_step[31:0];
                    r_prev  <= r_curr;
                    r_state <= S_T;
                end
                S_T: begin
                    r_x2    <= r_prod[62:32];
                    r_state <= S_U;
                end
                S_U: begin
                    r_t     <= t_full[32:0];
                    r_state <= S_UM;
                end
                S_UM: r_state <= S_Y;
                S_Y: begin
                    r_u     <= u_full[32:0];
                    r_state <= S_YM;
                end
                S_YM: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/fpso_checker.sv @@
module fpso_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [23:0] o_sample
);

    // an accepted item keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after item accepted");

    // a new sample only appears at the end of item work
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("sample appeared without item in work");

    // a stalled sample stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled sample dropped");

    // a stalled sample keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_sample))
        else $error("stalled sample changed");

endmodule

bind fluctuating_phase_sine_oscillator_top fpso_checker u_fpso_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sample    (o_sample)
);
